// File: hdl/ssum_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssum_pkg
// Shared constants, types and helpers for the target-sum counter.
// ----------------------------------------------------------------------------
package ssum_pkg;

   localparam int MAX_SUM      = 1023;
   localparam int COUNT_WIDTH  = 32;
   localparam int VALUE_WIDTH  = 10;
   localparam int TARGET_WIDTH = 11;
   localparam int WAYS_WIDTH   = 32;

   localparam int DEPTH = MAX_SUM + 1;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   // running sum before the bound check
   localparam int ADD_W = ((IDX_W > VALUE_WIDTH) ? IDX_W : VALUE_WIDTH) + 1;
   // signed arithmetic for the result index
   localparam int CALC_W = ((IDX_W > TARGET_WIDTH) ? IDX_W : TARGET_WIDTH) + 2;
   localparam int EXT_W  = (COUNT_WIDTH > WAYS_WIDTH) ? COUNT_WIDTH : WAYS_WIDTH;

   localparam int CSR_ADDR_W = 3;
   localparam logic CSR_IDX_TARGET = 1'b0;

   typedef logic [COUNT_WIDTH-1:0] count_type;
   typedef logic [IDX_W-1:0]       idx_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SWEEP,
      ST_DRAIN,
      ST_RES_RD,
      ST_RES_OUT
   } ssum_state_type;

   function automatic count_type sat_add(input count_type a, input count_type b);
      logic [COUNT_WIDTH:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : s[COUNT_WIDTH-1:0];
   endfunction

   function automatic logic [WAYS_WIDTH-1:0] sat_ways(input count_type c);
      logic [EXT_W-1:0] ext;
      logic [EXT_W-1:0] lim;
      ext = EXT_W'(c);
      lim = EXT_W'({WAYS_WIDTH{1'b1}});
      return (ext > lim) ? {WAYS_WIDTH{1'b1}} : ext[WAYS_WIDTH-1:0];
   endfunction

endpackage
`default_nettype wire

// File: hdl/subset_sum_target_count.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// subset_sum_target_count
// Counts sign assignments of a value set that reach a configured target.
// ----------------------------------------------------------------------------
// A set streams in one value per transaction, the final one marked by tlast.
// Each value v sweeps the 1024-entry count table top-down to entry v, one
// memory read-modify-write per cycle, holding off the next transaction
// until its sweep is done. The final value adds a result lookup, then a
// clearing pass rewrites the table before the next set is taken; the same
// clearing pass runs after reset. One result transaction per set: ways on
// tdata, overflow on tuser. The user writes target_sum over the APB port
// at address 0 only while the block idles; the block does not enforce it.
// ----------------------------------------------------------------------------
module subset_sum_target_count
   import ssum_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // configuration
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output logic      [31:0]           csr_prdata,
   output logic                       csr_pready,
   // input stream
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [15:0]           req_tdata,  // [9:0] value, rest zero
   input  wire logic                  req_tlast,  // last element of the set
   // result stream
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [31:0]                rsp_tdata,  // [31:0] ways
   output logic                       rsp_tuser   // [0] overflow
);

   logic signed [TARGET_WIDTH-1:0] target_ff, target_in;
   logic      csr_wr;
   logic      ram_we;
   idx_type   ram_waddr, ram_raddr_a, ram_raddr_b;
   count_type ram_wdata, ram_rdata_a, ram_rdata_b;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == CSR_IDX_TARGET);

   always_comb begin
      target_in = target_ff;
      if (csr_wr) begin
         target_in = csr_pwdata[TARGET_WIDTH-1:0];
      end
      csr_prdata = '0;
      if (csr_paddr[2] == CSR_IDX_TARGET) begin
         csr_prdata = 32'(target_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0;
      end else begin
         target_ff <= target_in;
      end
   end

   ssum_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .target_sum   (target_ff),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_value    (req_tdata[VALUE_WIDTH-1:0]),
      .req_last     (req_tlast),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_ways     (rsp_tdata),
      .rsp_overflow (rsp_tuser),
      .ram_we       (ram_we),
      .ram_waddr    (ram_waddr),
      .ram_wdata    (ram_wdata),
      .ram_raddr_a  (ram_raddr_a),
      .ram_raddr_b  (ram_raddr_b),
      .ram_rdata_a  (ram_rdata_a),
      .ram_rdata_b  (ram_rdata_b)
   );

   ssum_ram #(
      .DEPTH  (DEPTH),
      .WIDTH  (COUNT_WIDTH),
      .ADDR_W (IDX_W)
   ) u_table (
      .clock   (clock),
      .we      (ram_we),
      .waddr   (ram_waddr),
      .wdata   (ram_wdata),
      .raddr_a (ram_raddr_a),
      .raddr_b (ram_raddr_b),
      .rdata_a (ram_rdata_a),
      .rdata_b (ram_rdata_b)
   );

endmodule
`default_nettype wire

// File: hdl/ssum_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssum_ram
// Simple RAM: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module ssum_ram #(
   parameter int DEPTH  = 1024,
   parameter int WIDTH  = 32,
   parameter int ADDR_W = 10
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] waddr,
   input  wire logic [WIDTH-1:0]  wdata,
   input  wire logic [ADDR_W-1:0] raddr_a,
   input  wire logic [ADDR_W-1:0] raddr_b,
   output logic      [WIDTH-1:0]  rdata_a,
   output logic      [WIDTH-1:0]  rdata_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
   end

endmodule
`default_nettype wire

// File: hdl/ssum_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssum_ctrl
// Sequencer: table sweep, result lookup, clearing pass and result register.
// ----------------------------------------------------------------------------
module ssum_ctrl
   import ssum_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic signed [TARGET_WIDTH-1:0] target_sum,
   // input transaction
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   input  wire logic [VALUE_WIDTH-1:0]   req_value,
   input  wire logic                     req_last,
   // result transaction
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   output logic [WAYS_WIDTH-1:0]         rsp_ways,
   output logic                          rsp_overflow,
   // table memory
   output logic                          ram_we,
   output idx_type                       ram_waddr,
   output count_type                     ram_wdata,
   output idx_type                       ram_raddr_a,
   output idx_type                       ram_raddr_b,
   input  wire count_type                ram_rdata_a,
   input  wire count_type                ram_rdata_b
);

   localparam idx_type IDX_MAX = IDX_W'(MAX_SUM);

   ssum_state_type state_ff, state_in;
   idx_type        i_ff, i_in;
   logic [VALUE_WIDTH-1:0] v_ff, v_in;
   logic           last_ff, last_in;
   idx_type        total_ff, total_in;
   logic           ovf_ff, ovf_in;
   logic           p1_valid_ff, p1_valid_in;
   idx_type        p1_addr_ff, p1_addr_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [WAYS_WIDTH-1:0] rsp_ways_ff, rsp_ways_in;
   logic           rsp_ovf_ff, rsp_ovf_in;

   logic [ADD_W-1:0]         sum_w;
   logic signed [CALC_W-1:0] tgt_x, tot_x, mag, twice;
   logic                     res_ok;
   idx_type                  res_idx;
   logic                     rsp_load;

   // result index and validity from the finished total
   always_comb begin
      tgt_x   = CALC_W'(target_sum);
      tot_x   = signed'(CALC_W'(total_ff));
      mag     = (tgt_x < 0) ? -tgt_x : tgt_x;
      twice   = tgt_x + tot_x;
      res_ok  = !ovf_ff && (mag <= tot_x) && !twice[0];
      res_idx = twice[IDX_W:1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         i_ff         <= '0;
         total_ff     <= '0;
         ovf_ff       <= 1'b0;
         p1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         i_ff         <= i_in;
         total_ff     <= total_in;
         ovf_ff       <= ovf_in;
         p1_valid_ff  <= p1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      v_ff        <= v_in;
      last_ff     <= last_in;
      p1_addr_ff  <= p1_addr_in;
      rsp_ways_ff <= rsp_ways_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   always_comb begin
      state_in    = state_ff;
      i_in        = i_ff;
      v_in        = v_ff;
      last_in     = last_ff;
      total_in    = total_ff;
      ovf_in      = ovf_ff;
      p1_valid_in = 1'b0;
      p1_addr_in  = i_ff;
      req_tready  = 1'b0;
      rsp_load    = 1'b0;
      sum_w       = ADD_W'(total_ff) + ADD_W'(req_value);

      // second pipeline stage writes back the sweep entry
      ram_we      = p1_valid_ff;
      ram_waddr   = p1_addr_ff;
      ram_wdata   = sat_add(ram_rdata_a, ram_rdata_b);
      ram_raddr_a = i_ff;
      ram_raddr_b = i_ff - IDX_W'(v_ff);

      case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = i_ff;
            ram_wdata = (i_ff == '0) ? count_type'(1) : '0;
            if (i_ff == IDX_MAX) begin
               state_in = ST_IDLE;
            end else begin
               i_in = i_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               v_in    = req_value;
               last_in = req_last;
               i_in    = IDX_MAX;
               if (sum_w > ADD_W'(MAX_SUM)) begin
                  total_in = IDX_MAX;
                  ovf_in   = 1'b1;
               end else begin
                  total_in = sum_w[IDX_W-1:0];
               end
               if (ADD_W'(req_value) <= ADD_W'(MAX_SUM)) begin
                  state_in = ST_SWEEP;
               end else begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_SWEEP: begin
            // top-down, so the lower entry read is still the old count
            p1_valid_in = 1'b1;
            if (i_ff == IDX_W'(v_ff)) begin
               state_in = ST_DRAIN;
            end else begin
               i_in = i_ff - 1'b1;
            end
         end
         ST_DRAIN: begin
            state_in = last_ff ? ST_RES_RD : ST_IDLE;
         end
         ST_RES_RD: begin
            ram_raddr_a = res_idx;
            state_in    = ST_RES_OUT;
         end
         ST_RES_OUT: begin
            ram_raddr_a = res_idx;
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = ST_CLEAR;
               i_in     = '0;
               total_in = '0;
               ovf_in   = 1'b0;
            end
         end
         default: begin
            state_in = ST_CLEAR;
            i_in     = '0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_ways_in  = rsp_ways_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_ways_in  = res_ok ? sat_ways(ram_rdata_a) : '0;
         rsp_ovf_in   = ovf_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_ways     = rsp_ways_ff;
   assign rsp_overflow = rsp_ovf_ff;

endmodule
`default_nettype wire

// File: dv/subset_sum_target_count_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// subset_sum_target_count_tb
// Self-checking bench for the target-sum sign-assignment counter.
// ----------------------------------------------------------------------------
// Streams value sets into the block and keeps its own count table over the
// partial sums. Each accepted value updates that table. A last value computes
// the expected ways and overflow flag, which are compared with the next result
// transaction. The target is reprogrammed over APB between phases, once the
// block has drained and finished its clearing pass. A directed part covers
// the extreme values and targets, overflow, zero values and parity misses.
// Random phases follow, mostly with sets built to reach the target, plus noise
// and saturating sets. Both stream sides idle at random. The receiver holds off
// once for a long stretch so that the block backs up into its input.
// ----------------------------------------------------------------------------
module subset_sum_target_count_tb;
   import ssum_pkg::*;

   localparam int     CLEAR_PAUSE = 1100;     // covers the table clearing pass
   localparam int     HOLD_CYCLES = 12000;
   localparam int     ITEM_GOAL   = 580;
   localparam longint RUN_LIMIT   = 5_000_000;
   localparam int     TARGET_MAX  = 2 ** (TARGET_WIDTH - 1) - 1;
   localparam logic [CSR_ADDR_W-1:0] TARGET_ADDR = CSR_ADDR_W'(4 * int'(CSR_IDX_TARGET));

   class target_ways_scoreboard;
      typedef struct {
         logic [WAYS_WIDTH-1:0] ways;
         logic                  overflow;
      } set_result_type;

      count_type      counts [DEPTH];
      int             running_total;
      bit             total_overflowed;
      int             target;
      set_result_type pending [$];
      int             failures;

      function new();
         failures = 0;
         target   = 0;
         clear_set();
      endfunction

      function void clear_set();
         foreach (counts[i]) counts[i] = '0;
         counts[0]        = count_type'(1);
         running_total    = 0;
         total_overflowed = 0;
      endfunction

      // one accepted value: top-down table update, result on the last one
      function void note_value(int v, bit last);
         logic [COUNT_WIDTH:0] s;
         int                   mag;
         int                   twice;
         set_result_type       r;
         for (int i = MAX_SUM; i >= v; i--) begin
            s = {1'b0, counts[i]} + {1'b0, counts[i - v]};
            counts[i] = s[COUNT_WIDTH] ? '1 : s[COUNT_WIDTH-1:0];
         end
         if (running_total + v > MAX_SUM) begin
            total_overflowed = 1;
            running_total    = MAX_SUM;
         end else begin
            running_total += v;
         end
         if (!last) return;
         r.ways     = '0;
         r.overflow = total_overflowed;
         mag = (target < 0) ? -target : target;
         if (!total_overflowed && mag <= running_total) begin
            twice = target + running_total;
            if ((twice % 2) == 0 && twice / 2 <= MAX_SUM) r.ways = counts[twice / 2];
         end
         pending.push_back(r);
         clear_set();
      endfunction

      function void check_result(logic [31:0] ways, logic overflow);
         set_result_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result, ways %0d overflow %0b", $time, ways, overflow);
            failures++;
            return;
         end
         e = pending.pop_front();
         if (ways !== e.ways) begin
            $display("%0t: ways mismatch, expected %0d, actual %0d", $time, e.ways, ways);
            failures++;
         end
         if (overflow !== e.overflow) begin
            $display("%0t: overflow mismatch, expected %0b, actual %0b",
                     $time, e.overflow, overflow);
            failures++;
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0]           csr_pwdata;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [15:0]           req_tdata;   // [9:0] value, rest zero
   logic                  req_tlast;   // last element of the set
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [31:0]           rsp_tdata;   // [31:0] ways
   logic                  rsp_tuser;   // [0] overflow

   target_ways_scoreboard board;
   int                    items_sent;
   int                    cur_target;
   bit                    send_eager;

   subset_sum_target_count u_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // wait for every result and the clearing pass, then program the target
   task automatic write_target(int t);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (CLEAR_PAUSE) @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= TARGET_ADDR;
      csr_pwdata  <= 32'(t);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      cur_target   = t;
      board.target = t;
   endtask

   // req_tvalid is already low on the first value of a set
   task automatic send_value(int v, bit last, bit first);
      int gap;
      gap = send_eager ? 0 : $urandom_range(0, 9);
      if (first) begin
         if (gap == 0) gap = 1;
      end else if (gap > 0) begin
         req_tvalid <= 1'b0;
      end
      repeat (gap) @(posedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= 16'(v);
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      board.note_value(v, last);
      items_sent++;
   endtask

   task automatic send_list(int vals[$]);
      foreach (vals[k]) send_value(vals[k], k == vals.size() - 1, k == 0);
      req_tvalid <= 1'b0;
   endtask

   // with fit set, the last value tops the total up to |target| where it can, always with matching parity
   task automatic send_random_set(int n, int vmax, bit fit);
      int vals[$];
      int partial;
      int v;
      partial = 0;
      for (int k = 0; k < n; k++) begin
         v = $urandom_range(0, vmax);
         if (fit && k == n - 1) begin
            v = ((cur_target < 0) ? -cur_target : cur_target) - partial;
            if (v < 0) v = $urandom_range(0, vmax);
            if (v > MAX_SUM) v = MAX_SUM;
            if (((partial + v + cur_target) & 1) != 0) v = (v == MAX_SUM) ? v - 1 : v + 1;
         end
         vals.push_back(v);
         partial += v;
      end
      send_list(vals);
   endtask

   initial begin
      int  t;
      int  kind;
      int  sets;
      bit  force_saturation;
      reset       <= 1'b1;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tlast   <= 1'b0;
      board      = new();
      items_sent = 0;
      cur_target = 0;
      send_eager = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      write_target(0);
      send_list('{0});                 // +0 and -0: two ways
      send_list('{MAX_SUM, MAX_SUM});  // total past the bound
      send_list('{MAX_SUM});           // odd total, even target
      send_list('{5, 5});
      write_target(TARGET_MAX);
      send_list('{MAX_SUM});
      send_list('{512, 511});
      write_target(-TARGET_MAX);
      send_list('{MAX_SUM});
      send_list('{3});                 // target beyond minus the total
      write_target(-1);
      // receiver holds off here, so these sets back up into the input
      send_list('{1, 2});
      send_list('{2});                 // parity miss
      send_list('{1, 1, 1});
      send_list('{4, 3});

      force_saturation = 1;
      while (items_sent < ITEM_GOAL) begin
         case ($urandom_range(0, 9))
            0:       t = TARGET_MAX;
            1:       t = -TARGET_MAX;
            2:       t = int'($urandom_range(0, 2 * TARGET_MAX)) - TARGET_MAX;
            default: t = int'($urandom_range(0, 40)) - 20;
         endcase
         write_target(t);
         send_eager = ($urandom_range(0, 3) == 0);
         sets = $urandom_range(2, 6);
         for (int s = 0; s < sets && items_sent < ITEM_GOAL; s++) begin
            kind = force_saturation ? 39 : $urandom_range(0, 39);
            force_saturation = 0;
            if (kind < 28)
               send_random_set($urandom_range(1, 8), 30, 1);
            else if (kind < 31)
               send_random_set($urandom_range(1, 6), 300, 1);
            else if (kind < 36)
               send_random_set($urandom_range(1, 5), MAX_SUM, 0);
            else if (kind < 39)
               send_random_set($urandom_range(1, 6), 30, 0);
            else
               // mostly zeros: counts double up to saturation
               send_random_set($urandom_range(33, 36), $urandom_range(0, 1), 1);
         end
      end

      while (board.pending.size() != 0) @(posedge clock);
      repeat (CLEAR_PAUSE) @(posedge clock);
      if (board.failures == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   // result side: random stalls, bursts of none, one long hold-off
   initial begin
      int stall;
      int seen;
      bit eager;
      rsp_tready <= 1'b0;
      seen  = 0;
      eager = 0;
      wait (reset === 1'b0);
      forever begin
         if (seen % 8 == 0) eager = ($urandom_range(0, 2) == 0);
         if (seen == 8)
            stall = HOLD_CYCLES;
         else
            stall = eager ? 0 : $urandom_range(0, 9);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         board.check_result(rsp_tdata, rsp_tuser);
         seen++;
      end
   end

   initial begin
      repeat (RUN_LIMIT) @(posedge clock);
      $display("Simulation FAILED");
      $finish;
   end

endmodule
